FILE: rtl/core/pmm_pkg.sv
package pmm_pkg;

  // CORDIC datapath: signed Q2.30 values, angle accumulator one bit wider
  localparam int MAX_STEPS = 24;
  localparam int VAL_W     = 34;
  localparam int ANG_W     = 35;
  localparam int ENT_W     = 35;
  localparam int OUT_W     = 32;
  localparam int SCL_W     = 31;
  localparam int ANG_IN_W  = 16;
  localparam int ANG_SHIFT = 17;

  typedef logic signed [VAL_W-1:0] q30_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [OUT_W-1:0] word_t;

  localparam q30_t CORDIC_GAIN = 34'sd652032874;
  localparam ang_t PI_Q30      = 35'sd3373259426;
  localparam ang_t HALF_PI_Q30 = 35'sd1686629713;

  // arctangent of 2^-i, rounded to Q2.30
  function automatic ang_t atan_q30(input logic [4:0] idx);
    ang_t a;
    case (idx)
      5'd0:  a = 35'sd843314857;
      5'd1:  a = 35'sd497837829;
      5'd2:  a = 35'sd263043837;
      5'd3:  a = 35'sd133525159;
      5'd4:  a = 35'sd67021687;
      5'd5:  a = 35'sd33543516;
      5'd6:  a = 35'sd16775851;
      5'd7:  a = 35'sd8388437;
      5'd8:  a = 35'sd4194283;
      5'd9:  a = 35'sd2097149;
      5'd10: a = 35'sd1048576;
      5'd11: a = 35'sd524288;
      5'd12: a = 35'sd262144;
      5'd13: a = 35'sd131072;
      5'd14: a = 35'sd65536;
      5'd15: a = 35'sd32768;
      5'd16: a = 35'sd16384;
      5'd17: a = 35'sd8192;
      5'd18: a = 35'sd4096;
      5'd19: a = 35'sd2048;
      5'd20: a = 35'sd1024;
      5'd21: a = 35'sd512;
      5'd22: a = 35'sd256;
      5'd23: a = 35'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q2.30 product, rounded half up
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [2*VAL_W-1:0] p;
    p = a * b + 68'sd536870912;
    return q30_t'(p >>> 30);
  endfunction

  // rotation entry times scale, rounded and saturated to 32 bits
  function automatic word_t entry(input ent_t r, input logic [SCL_W-1:0] sc);
    logic signed [ENT_W+SCL_W:0] p;
    logic signed [ENT_W+SCL_W:0] v;
    word_t w;
    p = r * $signed({1'b0, sc}) + 67'sd536870912;
    v = p >>> 30;
    if (v > 67'sd2147483647) begin
      w = 32'sh7fffffff;
    end else if (v < -67'sd2147483648) begin
      w = 32'sh80000000;
    end else begin
      w = word_t'(v);
    end
    return w;
  endfunction

endpackage

FILE: rtl/core/pmm_if.sv
interface pmm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic [30:0]        scale_x;
  logic [30:0]        scale_y;
  logic [30:0]        scale_z;
  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

interface pmm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m03;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m13;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;
  logic signed [31:0] m23;
  modport source (output valid, m00, m01, m02, m03, m10, m11, m12, m13,
                  m20, m21, m22, m23, input ready);
  modport sink (input valid, m00, m01, m02, m03, m10, m11, m12, m13,
                m20, m21, m22, m23, output ready);
endinterface

FILE: rtl/core/pmm_cordic_lane.sv
module pmm_cordic_lane #(
  parameter int NUM_STEPS = 16
) (
  input  logic                                 clk,
  input  logic [NUM_STEPS:0]                   en,
  input  logic signed [pmm_pkg::ANG_IN_W-1:0]  angle,
  output pmm_pkg::q30_t                        sin_o,
  output pmm_pkg::q30_t                        cos_o
);
  import pmm_pkg::*;

  q30_t x_r    [0:NUM_STEPS];
  q30_t y_r    [0:NUM_STEPS];
  ang_t z_r    [0:NUM_STEPS];
  logic flip_r [0:NUM_STEPS];

  ang_t z_in;
  ang_t fold_z_nxt;
  logic fold_flip_nxt;

  // fold the angle into minus to plus a quarter turn
  always_comb begin
    z_in = ang_t'(angle) <<< ANG_SHIFT;
    fold_z_nxt = z_in;
    fold_flip_nxt = 1'b0;
    if (z_in > HALF_PI_Q30) begin
      fold_z_nxt = z_in - PI_Q30;
      fold_flip_nxt = 1'b1;
    end else if (z_in < -HALF_PI_Q30) begin
      fold_z_nxt = z_in + PI_Q30;
      fold_flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= fold_z_nxt;
      flip_r[0] <= fold_flip_nxt;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][ANG_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(5'(i));
        end
      end
    end
  end

  assign sin_o = flip_r[NUM_STEPS] ? -y_r[NUM_STEPS] : y_r[NUM_STEPS];
  assign cos_o = flip_r[NUM_STEPS] ? -x_r[NUM_STEPS] : x_r[NUM_STEPS];

endmodule

FILE: rtl/core/pmm_merge.sv
module pmm_merge (
  input  logic                        clk,
  input  logic [3:0]                  en,
  input  pmm_pkg::q30_t               sx,
  input  pmm_pkg::q30_t               cx,
  input  pmm_pkg::q30_t               sy,
  input  pmm_pkg::q30_t               cy,
  input  pmm_pkg::q30_t               sz,
  input  pmm_pkg::q30_t               cz,
  input  logic [pmm_pkg::SCL_W-1:0]   scale [0:2],
  output pmm_pkg::word_t              ent_o [0:8]
);
  import pmm_pkg::*;

  // first products
  q30_t cycz_r, cysz_r, cxsz_r, cxcz_r, sxcy_r, cxcy_r;
  q30_t sxsy_r, cxsy_r, sxsz_r, sxcz_r, cz1_r, sz1_r, sy1_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cycz_r <= mulq(cy, cz);
      cysz_r <= mulq(cy, sz);
      cxsz_r <= mulq(cx, sz);
      cxcz_r <= mulq(cx, cz);
      sxcy_r <= mulq(sx, cy);
      cxcy_r <= mulq(cx, cy);
      sxsy_r <= mulq(sx, sy);
      cxsy_r <= mulq(cx, sy);
      sxsz_r <= mulq(sx, sz);
      sxcz_r <= mulq(sx, cz);
      cz1_r  <= cz;
      sz1_r  <= sz;
      sy1_r  <= sy;
    end
  end

  // second products of the three-term entries
  q30_t a_r, b_r, c_r, d_r;
  q30_t cycz2_r, cysz2_r, cxsz2_r, cxcz2_r, sxcy2_r, cxcy2_r, sxsz2_r, sxcz2_r, sy2_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      a_r     <= mulq(sxsy_r, cz1_r);
      b_r     <= mulq(sxsy_r, sz1_r);
      c_r     <= mulq(cxsy_r, cz1_r);
      d_r     <= mulq(cxsy_r, sz1_r);
      cycz2_r <= cycz_r;
      cysz2_r <= cysz_r;
      cxsz2_r <= cxsz_r;
      cxcz2_r <= cxcz_r;
      sxcy2_r <= sxcy_r;
      cxcy2_r <= cxcy_r;
      sxsz2_r <= sxsz_r;
      sxcz2_r <= sxcz_r;
      sy2_r   <= sy1_r;
    end
  end

  // rotation entries
  ent_t r_r [0:8];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      r_r[0] <= ent_t'(cycz2_r);
      r_r[1] <= -ent_t'(cysz2_r);
      r_r[2] <= ent_t'(sy2_r);
      r_r[3] <= ent_t'(cxsz2_r) + ent_t'(a_r);
      r_r[4] <= ent_t'(cxcz2_r) - ent_t'(b_r);
      r_r[5] <= -ent_t'(sxcy2_r);
      r_r[6] <= ent_t'(sxsz2_r) - ent_t'(c_r);
      r_r[7] <= ent_t'(sxcz2_r) + ent_t'(d_r);
      r_r[8] <= ent_t'(cxcy2_r);
    end
  end

  // scale by column, round and saturate into the output register
  word_t ent_r [0:8];
  for (genvar k = 0; k < 9; k++) begin : g_ent
    always_ff @(posedge clk) begin
      if (en[3]) begin
        ent_r[k] <= entry(r_r[k], scale[k % 3]);
      end
    end
    assign ent_o[k] = ent_r[k];
  end

endmodule

FILE: rtl/core/pose_to_model_matrix_top.sv
// Pose to model matrix, M = T * Rx * Ry * Rz * S.
// Input channel in_ch: one transaction carries a box pose (position Q16.16,
// Euler angles Q3.13 radians, scales Q16.16). Output channel out_ch: one
// transaction per pose with the top three rows of M, Q16.16, saturated.
// Both channels use valid/ready; a transaction completes when both are high.
// Stages from input to output valid: one fold stage, one stage per CORDIC
// iteration, two multiply stages, one add stage, one scale/saturate stage
// that is also the output register.
// Throughput: one pose per cycle unless the receiver stalls; the three angles
// run in parallel CORDIC lanes and every stage holds its own transaction.
// When the receiver stalls, each stage holds; a stage with a bubble still
// fills, so in_ch.ready only drops once every stage is occupied.
// Reset (rst_n low, synchronous) clears all stage valid flags; pipeline
// data is not reset.
module pose_to_model_matrix_top #(
  parameter int CORDIC_STEPS = 16
) (
  input logic    clk,
  input logic    rst_n,
  pmm_in_if.sink    in_ch,
  pmm_out_if.source out_ch
);
  import pmm_pkg::*;

  localparam int NS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int S  = NS + 5;

  logic [S-1:0] v_r;
  logic [S-1:0] rdy;

  // stage moves when empty or when the next stage moves
  always_comb begin
    rdy[S-1] = !v_r[S-1] || out_ch.ready;
    for (int k = S - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < S; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready = rdy[0];

  // position and scale travel beside the datapath
  word_t             pos_r [0:S-1][0:2];
  logic [SCL_W-1:0]  scl_r [0:S-1][0:2];
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pos_r[0][0] <= in_ch.pos_x;
      pos_r[0][1] <= in_ch.pos_y;
      pos_r[0][2] <= in_ch.pos_z;
      scl_r[0][0] <= in_ch.scale_x;
      scl_r[0][1] <= in_ch.scale_y;
      scl_r[0][2] <= in_ch.scale_z;
    end
    for (int k = 1; k < S; k++) begin
      if (rdy[k]) begin
        pos_r[k] <= pos_r[k-1];
        scl_r[k] <= scl_r[k-1];
      end
    end
  end

  // one CORDIC lane per angle
  q30_t sx, cx, sy, cy, sz, cz;
  pmm_cordic_lane #(.NUM_STEPS(NS)) u_lane_x (
    .clk(clk), .en(rdy[NS:0]), .angle(in_ch.angle_x), .sin_o(sx), .cos_o(cx)
  );
  pmm_cordic_lane #(.NUM_STEPS(NS)) u_lane_y (
    .clk(clk), .en(rdy[NS:0]), .angle(in_ch.angle_y), .sin_o(sy), .cos_o(cy)
  );
  pmm_cordic_lane #(.NUM_STEPS(NS)) u_lane_z (
    .clk(clk), .en(rdy[NS:0]), .angle(in_ch.angle_z), .sin_o(sz), .cos_o(cz)
  );

  // combine lanes into the scaled rotation
  word_t ent [0:8];
  pmm_merge u_merge (
    .clk(clk), .en(rdy[S-1:NS+1]),
    .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
    .scale(scl_r[S-2]), .ent_o(ent)
  );

  assign out_ch.valid = v_r[S-1];
  assign out_ch.m00 = ent[0];
  assign out_ch.m01 = ent[1];
  assign out_ch.m02 = ent[2];
  assign out_ch.m03 = pos_r[S-1][0];
  assign out_ch.m10 = ent[3];
  assign out_ch.m11 = ent[4];
  assign out_ch.m12 = ent[5];
  assign out_ch.m13 = pos_r[S-1][1];
  assign out_ch.m20 = ent[6];
  assign out_ch.m21 = ent[7];
  assign out_ch.m22 = ent[8];
  assign out_ch.m23 = pos_r[S-1][2];

`ifndef SYNTH
  // input only backs up once every stage holds a transaction
  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled with a bubble in the pipeline");

  // nothing leaves the pipeline right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  // a transaction at the input reaches the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted transaction lost at first stage");
`endif

endmodule

FILE: tb/sv/pmm_tb_if.sv
`timescale 1ns / 1ps

// Clocked wrappers are not needed: the RTL interfaces are used directly.
// This file holds the pose and matrix records shared by the testbench.
package pmm_tb_pkg;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] angle_x, angle_y, angle_z;
    logic [30:0]        scale_x, scale_y, scale_z;
  } pose_t;

  typedef struct {
    logic signed [31:0] m [12];
  } matrix_t;

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pmm_pkg::*;
  import pmm_tb_pkg::*;

  localparam int STEPS   = 16;
  localparam int LATENCY = STEPS + 5;
  localparam int N_RAND  = 1400;
  localparam logic signed [15:0] ANG_MAX = 16'sd25736;

  logic clk;
  logic rst_n;

  pmm_in_if  in_ch();
  pmm_out_if out_ch();

  pose_to_model_matrix_top #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Independent model of the matrix computation, widths in 64-bit signed
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b + 64'sd536870912, 30);
  endfunction

  function automatic longint arctan_step(int i);
    longint tab [24] = '{843314857, 497837829, 263043837, 133525159,
                         67021687, 33543516, 16775851, 8388437,
                         4194283, 2097149, 1048576, 524288,
                         262144, 131072, 65536, 32768,
                         16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return tab[i];
  endfunction

  function automatic void rotate_sincos(input logic signed [15:0] ang,
                                        output longint s, output longint c);
    longint z, x, y, nx;
    bit     flip;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= arctan_step(i);
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += arctan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic signed [31:0] scaled_entry(longint r, longint sc);
    longint v;
    v = floor_shr(r * sc + 64'sd536870912, 30);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic matrix_t model_matrix(pose_t p);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint r [3][3];
    longint sc [3];
    longint pos [3];
    matrix_t m;
    rotate_sincos(p.angle_x, sx, cx);
    rotate_sincos(p.angle_y, sy, cy);
    rotate_sincos(p.angle_z, sz, cz);
    sc  = '{longint'(p.scale_x), longint'(p.scale_y), longint'(p.scale_z)};
    pos = '{longint'(p.pos_x), longint'(p.pos_y), longint'(p.pos_z)};
    sxsy = q30_mul(sx, sy);
    cxsy = q30_mul(cx, sy);
    r[0][0] = q30_mul(cy, cz);
    r[0][1] = -q30_mul(cy, sz);
    r[0][2] = sy;
    r[1][0] = q30_mul(cx, sz) + q30_mul(sxsy, cz);
    r[1][1] = q30_mul(cx, cz) - q30_mul(sxsy, sz);
    r[1][2] = -q30_mul(sx, cy);
    r[2][0] = q30_mul(sx, sz) - q30_mul(cxsy, cz);
    r[2][1] = q30_mul(sx, cz) + q30_mul(cxsy, sz);
    r[2][2] = q30_mul(cx, cy);
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) m.m[row*4+col] = scaled_entry(r[row][col], sc[col]);
      m.m[row*4+3] = pos[row][31:0];
    end
    return m;
  endfunction

  // Scoreboard: queue of predicted matrices in pose order
  class matrix_board;
    matrix_t pending_matrices [$];
    int      n_checked;
    int      n_errors;

    function void note_pose(pose_t p);
      pending_matrices.push_back(model_matrix(p));
    endfunction

    function void check_matrix(matrix_t got);
      matrix_t want;
      if (pending_matrices.size() == 0) begin
        $error("unexpected matrix transaction");
        n_errors++;
        return;
      end
      want = pending_matrices.pop_front();
      n_checked++;
      for (int k = 0; k < 12; k++) begin
        if (got.m[k] !== want.m[k]) begin
          $error("m%0d%0d: expected %0d, actual %0d", k / 4, k % 4, want.m[k], got.m[k]);
          n_errors++;
        end
      end
    endfunction
  endclass

  matrix_board board = new();
  pose_t       poses [$];
  bit          stim_done;
  bit          long_hold;
  int          n_sent;

  // Clock and reset
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
  end

  // Short gaps mostly, a long one now and then
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] rand_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom());
    return 16'($urandom_range(0, 2 * 25736) - 25736);
  endfunction

  function automatic logic [30:0] rand_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 31'($urandom_range(0, 32'h0008_0000));
    return 31'($urandom());
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.pos_x = $urandom(); p.pos_y = $urandom(); p.pos_z = $urandom();
    p.angle_x = rand_angle(); p.angle_y = rand_angle(); p.angle_z = rand_angle();
    p.scale_x = rand_scale(); p.scale_y = rand_scale(); p.scale_z = rand_scale();
    return p;
  endfunction

  function automatic pose_t make_pose(logic signed [31:0] p,
                                      logic signed [15:0] a, logic [30:0] s);
    pose_t q;
    q.pos_x = p; q.pos_y = -p; q.pos_z = ~p;
    q.angle_x = a; q.angle_y = -a; q.angle_z = a;
    q.scale_x = s; q.scale_y = s; q.scale_z = s;
    return q;
  endfunction

  // Directed poses: extreme fields, quarter turn folds, saturation
  task automatic build_directed();
    poses.push_back(make_pose(0, 0, 31'h0001_0000));
    poses.push_back(make_pose(32'sh7fffffff, ANG_MAX, 31'h7fffffff));
    poses.push_back(make_pose(32'sh80000000, -ANG_MAX, 31'h7fffffff));
    poses.push_back(make_pose(32'sh0001_0000, 16'sd12868, 31'h0001_0000));
    poses.push_back(make_pose(32'sh0001_0000, 16'sd12869, 31'h0001_0000));
    poses.push_back(make_pose(32'sh0001_0000, -16'sd12869, 31'h0001_0000));
    poses.push_back(make_pose(32'sh1234_5678, 16'sh7fff, 31'h4000_0000));
    poses.push_back(make_pose(-32'sd1, 16'sh8000, 31'h0));
    poses.push_back(make_pose(32'sh5555_5555, 16'sh5555, 31'h2aaa_aaaa));
    poses.push_back(make_pose(32'shaaaa_aaaa, 16'shaaaa, 31'h5555_5555));
    poses.push_back(make_pose(32'sh0000_8000, 16'sd6434, 31'h7fff_0000));
    poses.push_back(make_pose(32'sh0, 16'sd25736, 31'h1));
    for (int i = 0; i < 6; i++) begin
      pose_t p;
      p = rand_pose();
      p.scale_x = 31'h7fffffff; p.scale_y = 31'h7fffffff; p.scale_z = 31'h7fffffff;
      poses.push_back(p);
    end
  endtask

  // Pose driver
  initial begin
    int g;
    in_ch.valid   <= 0;
    in_ch.pos_x   <= '0; in_ch.pos_y   <= '0; in_ch.pos_z   <= '0;
    in_ch.angle_x <= '0; in_ch.angle_y <= '0; in_ch.angle_z <= '0;
    in_ch.scale_x <= '0; in_ch.scale_y <= '0; in_ch.scale_z <= '0;
    stim_done = 0;
    build_directed();
    for (int i = 0; i < N_RAND; i++) poses.push_back(rand_pose());
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (poses.size() > 0) begin
      pose_t p;
      p = poses.pop_front();
      in_ch.valid   <= 1;
      in_ch.pos_x   <= p.pos_x;   in_ch.pos_y   <= p.pos_y;   in_ch.pos_z   <= p.pos_z;
      in_ch.angle_x <= p.angle_x; in_ch.angle_y <= p.angle_y; in_ch.angle_z <= p.angle_z;
      in_ch.scale_x <= p.scale_x; in_ch.scale_y <= p.scale_y; in_ch.scale_z <= p.scale_z;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      board.note_pose(p);
      n_sent++;
      // no idling while the receiver is held off, so the pipeline fills
      g = long_hold ? 0 : ((n_sent % 300) < 40 ? 0 : gap_len());
      if (g > 0 || poses.size() == 0) begin
        in_ch.valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
    stim_done = 1;
  end

  // Matrix receiver, with one long hold-off early in the random part
  initial begin
    int g;
    bit held;
    out_ch.ready <= 0;
    long_hold = 0;
    held = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && n_sent >= 60) begin
        held = 1;
        long_hold = 1;
        out_ch.ready <= 0;
        repeat (3 * LATENCY + 20) @(posedge clk);
        long_hold = 0;
      end
      g = (board.n_checked % 300) < 40 ? 0 : gap_len();
      if (g > 0) begin
        out_ch.ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      begin
        matrix_t got;
        got.m = '{out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m03,
                  out_ch.m10, out_ch.m11, out_ch.m12, out_ch.m13,
                  out_ch.m20, out_ch.m21, out_ch.m22, out_ch.m23};
        board.check_matrix(got);
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (board.pending_matrices.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d poses, checked %0d matrices, including folds and saturation.",
             n_sent, board.n_checked);
    if (board.n_errors == 0 && board.pending_matrices.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
